/* hw/rtl/countdown_timer_block_with_cnt64_unit_assert.svh */
// Assertion macros shared by the timer block's modules.
`ifndef COUNTDOWN_TIMER_BLOCK_WITH_CNT64_UNIT_ASSERT_SVH
`define COUNTDOWN_TIMER_BLOCK_WITH_CNT64_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks prop at every rising edge outside reset.
`define CDT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("timer block assertion failed");

// Checks that cons holds in the cycle after ante.
`define CDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timer block assertion failed");

`else

`define CDT_ASSERT(lbl, clk, rstn, prop)
`define CDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/cdt_pkg.sv */
package cdt_pkg;

    localparam int NUM_TIMERS = 3;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

    // Fixed register offsets
    localparam logic [7:0] OFS_IER     = 8'h00;
    localparam logic [7:0] OFS_ISR     = 8'h04;
    localparam logic [7:0] OFS_C64CTRL = 8'ha0;
    localparam logic [7:0] OFS_C64LO   = 8'ha4;
    localparam logic [7:0] OFS_C64HI   = 8'ha8;

    // Word offsets inside one timer's 16-byte window
    localparam logic [3:0] SUB_CTL = 4'h0;
    localparam logic [3:0] SUB_INT = 4'h4;
    localparam logic [3:0] SUB_CUR = 4'h8;

    // Control register bits
    localparam int CTL_EN_BIT      = 0;
    localparam int CTL_RELOAD_BIT  = 1;
    localparam int CTL_ONESHOT_BIT = 7;
    localparam int CTL_PRE_LO      = 4;
    localparam int CTL_PRE_HI      = 6;

    // 64-bit counter command bits
    localparam int C64_CLEAR_BIT = 0;
    localparam int C64_LATCH_BIT = 1;

    typedef struct packed {
        logic tick;
        logic ctl_we;
        logic int_we;
        logic cur_we;
    } chan_cmd_t;

endpackage

/* hw/rtl/cdt_chan.sv */
`include "countdown_timer_block_with_cnt64_unit_assert.svh"

module cdt_chan (
    input  logic              aclk,
    input  logic              aresetn,
    input  cdt_pkg::chan_cmd_t cmd,
    input  logic [31:0]       wdata,
    output logic [7:0]        ctl,
    output logic [31:0]       interval,
    output logic [31:0]       current,
    output logic              expire
);
    import cdt_pkg::*;

    logic [7:0]  ctl_reg, ctl_next;
    logic [31:0] int_reg, int_next;
    logic [31:0] cur_reg, cur_next;
    logic [6:0]  pc_reg, pc_next;
    logic [7:0]  pc_inc;
    logic [7:0]  period;

    assign pc_inc = {1'b0, pc_reg} + 8'd1;
    assign period = 8'd1 << ctl_reg[CTL_PRE_HI:CTL_PRE_LO];

    always_comb begin
        ctl_next = ctl_reg;
        int_next = int_reg;
        cur_next = cur_reg;
        pc_next  = pc_reg;
        expire   = 1'b0;
        if (cmd.tick && ctl_reg[CTL_EN_BIT]) begin
            if (pc_inc < period) begin
                pc_next = pc_inc[6:0];
            end else begin
                pc_next = '0;
                if (cur_reg > 32'd1) begin
                    cur_next = cur_reg - 32'd1;
                end else begin
                    expire = 1'b1;
                    if (ctl_reg[CTL_ONESHOT_BIT]) begin
                        ctl_next[CTL_EN_BIT] = 1'b0;
                        cur_next = '0;
                    end else begin
                        cur_next = int_reg;
                    end
                end
            end
        end
        if (cmd.ctl_we) begin
            ctl_next = wdata[7:0];
            ctl_next[CTL_RELOAD_BIT] = 1'b0;
            if (wdata[CTL_RELOAD_BIT]) begin
                cur_next = int_reg;
                pc_next  = '0;
            end
        end
        if (cmd.int_we) begin
            int_next = wdata;
        end
        if (cmd.cur_we) begin
            cur_next = wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
            int_reg <= '0;
            cur_reg <= '0;
            pc_reg  <= '0;
        end else begin
            ctl_reg <= ctl_next;
            int_reg <= int_next;
            cur_reg <= cur_next;
            pc_reg  <= pc_next;
        end
    end

    assign ctl      = ctl_reg;
    assign interval = int_reg;
    assign current  = cur_reg;

    `CDT_ASSERT(a_expire_needs_tick, aclk, aresetn, !expire || (cmd.tick && ctl_reg[CTL_EN_BIT]))
    `CDT_ASSERT_NEXT(a_oneshot_stops, aclk, aresetn, expire && ctl_reg[CTL_ONESHOT_BIT], !ctl_reg[CTL_EN_BIT] && (cur_reg == '0))
    `CDT_ASSERT_NEXT(a_cont_reloads, aclk, aresetn, expire && !ctl_reg[CTL_ONESHOT_BIT], cur_reg == int_reg)

endmodule

/* hw/rtl/countdown_timer_block_with_cnt64_unit.sv */
// Timer peripheral with NUM_TIMERS prescaled down-counters, a masked
// interrupt line and a free-running 64-bit counter, driven by a stream of
// items that are register reads, register writes or single clock ticks.
// Every item gives exactly one result holding the read value (zero for
// writes and ticks) and the interrupt line as it stands after the item.
// One item is taken in every cycle; each passes an input register, a state
// update and a result register, so a result is presented on the master side
// from the result register once its item has left the input register.
// Items stall only when the result register is full and not being taken.
`include "countdown_timer_block_with_cnt64_unit_assert.svh"

module countdown_timer_block_with_cnt64_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // reg_offset[7:0], write_data[39:8]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data[31:0], irq_line[32], zero[39:33]
);
    import cdt_pkg::*;

    logic              in_valid_reg, in_valid_next;
    req_type_t         in_type_reg;
    logic [7:0]        in_off_reg;
    logic [31:0]       in_data_reg;
    logic              s_accept;
    logic              proc_fire;
    logic              is_tick, is_write, is_read;

    logic              out_valid_reg, out_valid_next;
    logic [39:0]       out_data_reg;

    logic [NUM_TIMERS-1:0] ier_reg, ier_next;
    logic [NUM_TIMERS-1:0] pend_reg, pend_next;
    logic [63:0]           fc_reg, fc_next;
    logic [63:0]           lat_reg, lat_next;

    chan_cmd_t             cmd    [NUM_TIMERS];
    logic [7:0]            ctl    [NUM_TIMERS];
    logic [31:0]           intv   [NUM_TIMERS];
    logic [31:0]           cur    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] expire;
    logic [NUM_TIMERS-1:0] hit;

    logic [31:0]           rd;
    logic                  irq;
    logic                  irq_state;

    // The stage moves on whenever the result register is free or being emptied.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_accept  = s_tvalid && s_tready;

    assign is_tick  = proc_fire && (in_type_reg == REQ_TICK);
    assign is_write = proc_fire && (in_type_reg == REQ_WRITE);
    assign is_read  = in_type_reg == REQ_READ;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg <= req_type_t'(s_tuser);
            in_off_reg  <= s_tdata[7:0];
            in_data_reg <= s_tdata[39:8];
        end
    end

    // Timer i occupies the 16-byte window starting at 0x10 * (i + 1).
    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_chan
        assign hit[i] = in_off_reg[7:4] == 4'(i + 1);
        assign cmd[i].tick   = is_tick;
        assign cmd[i].ctl_we = is_write && hit[i] && (in_off_reg[3:0] == SUB_CTL);
        assign cmd[i].int_we = is_write && hit[i] && (in_off_reg[3:0] == SUB_INT);
        assign cmd[i].cur_we = is_write && hit[i] && (in_off_reg[3:0] == SUB_CUR);

        cdt_chan u_chan (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd[i]),
            .wdata    (in_data_reg),
            .ctl      (ctl[i]),
            .interval (intv[i]),
            .current  (cur[i]),
            .expire   (expire[i])
        );
    end

    always_comb begin
        ier_next  = ier_reg;
        pend_next = pend_reg;
        fc_next   = fc_reg;
        lat_next  = lat_reg;
        if (is_tick) begin
            fc_next   = fc_reg + 64'd1;
            pend_next = pend_reg | expire;
        end
        if (is_write) begin
            case (in_off_reg)
                OFS_IER: begin
                    ier_next = in_data_reg[NUM_TIMERS-1:0];
                end
                OFS_ISR: begin
                    pend_next = pend_reg & ~in_data_reg[NUM_TIMERS-1:0];
                end
                OFS_C64CTRL: begin
                    // A clear together with a latch captures zero.
                    if (in_data_reg[C64_CLEAR_BIT]) begin
                        fc_next = '0;
                    end
                    if (in_data_reg[C64_LATCH_BIT]) begin
                        lat_next = in_data_reg[C64_CLEAR_BIT] ? 64'd0 : fc_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rd = '0;
        if (is_read) begin
            case (in_off_reg)
                OFS_IER:   rd = 32'(ier_reg);
                OFS_ISR:   rd = 32'(pend_reg);
                OFS_C64LO: rd = lat_reg[31:0];
                OFS_C64HI: rd = lat_reg[63:32];
                default: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (hit[i]) begin
                            case (in_off_reg[3:0])
                                SUB_CTL: rd = 32'(ctl[i]);
                                SUB_INT: rd = intv[i];
                                SUB_CUR: rd = cur[i];
                                default: rd = '0;
                            endcase
                        end
                    end
                end
            endcase
        end
    end

    assign irq       = |(pend_next & ier_next);
    assign irq_state = |(pend_reg & ier_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ier_reg  <= '0;
            pend_reg <= '0;
            fc_reg   <= '0;
            lat_reg  <= '0;
        end else begin
            ier_reg  <= ier_next;
            pend_reg <= pend_next;
            fc_reg   <= fc_next;
            lat_reg  <= lat_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            out_data_reg <= {7'd0, irq, rd};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `CDT_ASSERT(a_irq_matches_state, aclk, aresetn, !out_valid_reg || (out_data_reg[32] == irq_state))
    `CDT_ASSERT_NEXT(a_pend_only_on_tick, aclk, aresetn, !is_tick, (pend_reg & ~$past(pend_reg)) == '0)
    `CDT_ASSERT_NEXT(a_counter_counts, aclk, aresetn, is_tick, fc_reg == ($past(fc_reg) + 64'd1))
    `CDT_ASSERT(a_stall_needs_item, aclk, aresetn, s_tready || in_valid_reg)

endmodule
